// ----- src/mlbc_pkg.sv -----
// shared types, constants and codes of the multi-led blink controller
// no dependencies; imported by every module of the block
package mlbc_pkg;

	// default channel count and register reset values
	localparam int LED_COUNT_DEF = 8;
	localparam logic [15:0] FAST_PERIOD_RST = 16'd50;
	localparam logic [15:0] SLOW_PERIOD_RST = 16'd200;
	localparam logic [31:0] DUR_FOREVER = 32'hFFFF_FFFF;

	// field widths
	localparam int MODE_W = 3;
	localparam int TIME_W = 32;
	localparam int PER_W = 16;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// command kinds carried in tuser
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET = 1'b1;

	// led modes, codes above MODE_DEVICE behave as device
	localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FAST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SLOW = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEVICE = 3'd4;

	// configuration register indexes
	localparam logic REG_FAST = 1'b0;
	localparam logic REG_SLOW = 1'b1;

	// one led table entry, start time zero means idle
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] start;
		logic [PER_W-1:0] period;
		logic [TIME_W-1:0] expiry;
	} led_entry_t;

	// control handed to the entry update unit
	typedef struct packed {
		logic is_set;
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] dur;
		logic [TIME_W-1:0] millis;
		logic [PER_W-1:0] fast_period;
		logic [PER_W-1:0] slow_period;
	} upd_ctl_t;

endpackage

// ----- src/mlbc_led_update.sv -----
// next-state logic for one led table entry: mode assignment or poll after a tick
// depends on mlbc_pkg
module mlbc_led_update import mlbc_pkg::*; (
	input  upd_ctl_t   ctl,
	input  led_entry_t entry_cur,
	input  logic       level_cur,
	output led_entry_t entry_nxt,
	output logic       level_nxt
);

	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] adv_start;
	logic              is_blink;
	logic              due;
	logic              expired;

	always_comb begin
		elapsed = ctl.millis - entry_cur.start;
		adv_start = entry_cur.start + TIME_W'(entry_cur.period);
		is_blink = (ctl.mode == MODE_FAST) || (ctl.mode == MODE_SLOW);
		due = (entry_cur.start != '0) && (elapsed >= TIME_W'(entry_cur.period));
		expired = (entry_cur.expiry != DUR_FOREVER) && (entry_cur.expiry <= ctl.millis);
		entry_nxt = entry_cur;
		level_nxt = level_cur;

		if (ctl.is_set) begin
			// assign a mode, keep a running timer so blinks hold their phase
			entry_nxt.mode = ctl.mode;
			if (entry_cur.start == '0)
				entry_nxt.start = ctl.millis;
			entry_nxt.period = '0;
			entry_nxt.expiry = ctl.dur;
			if (is_blink) begin
				entry_nxt.period = (ctl.mode == MODE_FAST) ? ctl.fast_period : ctl.slow_period;
				if (ctl.dur != DUR_FOREVER)
					entry_nxt.expiry = ctl.millis + ctl.dur;
			end
		end else if (due) begin
			// poll: act on the mode once the period has run out
			case (entry_cur.mode)
				MODE_OFF, MODE_ON: begin
					level_nxt = (entry_cur.mode == MODE_ON);
					entry_nxt.start = '0;
				end
				MODE_FAST, MODE_SLOW: begin
					level_nxt = ~level_cur;
					entry_nxt.start = adv_start;
					if (expired) begin
						// blink ran out: fall back to off, timer keeps running
						entry_nxt.mode = MODE_OFF;
						if (adv_start == '0)
							entry_nxt.start = ctl.millis;
						entry_nxt.period = '0;
						entry_nxt.expiry = '0;
					end
				end
				default: begin
					entry_nxt.start = '0;
				end
			endcase
		end
	end

endmodule

// ----- src/multi_led_blink_controller_core.sv -----
// top level of the multi-led blink controller: led table memory, sequencer, ports
// depends on mlbc_pkg and mlbc_led_update
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: command; tdata: led_index, new_mode, duration_ms
// m_*      out  m_tvalid/m_tready  tdata: led_levels
// wr_*     in   wr_en              wr_index selects fast/slow period, wr_data value
//
// set-mode item: from acceptance to result it reads the entry, updates and writes it, then loads the output
// tick item: one table entry read and written back per cycle
// through the led table memory, one read port and one write port
// reset clears the millisecond counter, levels and per-entry valid bits at once
// a result that is not taken holds the next item in the output load step only
module multi_led_blink_controller_core import mlbc_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata: led_index[2:0], new_mode[5:3], duration_ms[37:6], zero pad
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: command
	input  logic                 s_tuser,
	// m_tdata: led_levels[7:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 wr_en,
	input  logic                 wr_index,
	input  logic [PER_W-1:0]     wr_data
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SET = 2'd1;
	localparam logic [1:0] ST_POLL = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0]           state_q;
	logic [PER_W-1:0]     fast_q;
	logic [PER_W-1:0]     slow_q;
	logic [TIME_W-1:0]    millis_q;
	logic [MODE_W-1:0]    mode_q;
	logic [TIME_W-1:0]    dur_q;
	logic [IDX_W:0]       cnt_q;
	logic [IDX_W-1:0]     addr_s1;
	led_entry_t           rd_entry_s1;
	logic                 rd_vld_s1;
	logic [LED_COUNT-1:0] vld_q;
	logic [LED_COUNT-1:0] level_q;
	logic [M_TDATA_W-1:0] out_q;
	logic                 ov_q;

	led_entry_t           mem [LED_COUNT];

	logic                 in_acc;
	logic [IDX_W+2:0]     idx_w;
	logic                 idx_ok;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_mem;
	logic                 out_load;
	upd_ctl_t             ctl;
	led_entry_t           entry_cur;
	led_entry_t           entry_nxt;
	logic                 level_nxt;
	logic [LED_COUNT+M_TDATA_W-1:0] lv_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign idx_w = (IDX_W+3)'(s_tdata[2:0]);
	assign idx_ok = idx_w < (IDX_W+3)'(LED_COUNT);
	assign wr_mem = (state_q == ST_SET) || (state_q == ST_POLL);
	assign out_load = (state_q == ST_OUT) && (!ov_q || m_tready);
	assign lv_ext = {{M_TDATA_W{1'b0}}, level_q};
	assign m_tvalid = ov_q;
	assign m_tdata = out_q;

	// table read address: accepted item or the poll sweep
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (in_acc) begin
			rd_en = 1'b1;
			if (s_tuser == CMD_SET)
				rd_addr = idx_w[IDX_W-1:0];
		end else if (state_q == ST_POLL && cnt_q < (IDX_W+1)'(LED_COUNT)) begin
			rd_en = 1'b1;
			rd_addr = cnt_q[IDX_W-1:0];
		end
	end

	// entries never written read as the reset value
	always_comb begin
		entry_cur = rd_vld_s1 ? rd_entry_s1 : '0;
		ctl.is_set = (state_q == ST_SET);
		ctl.mode = mode_q;
		ctl.dur = dur_q;
		ctl.millis = millis_q;
		ctl.fast_period = fast_q;
		ctl.slow_period = slow_q;
	end

	mlbc_led_update u_update (
		.ctl       (ctl),
		.entry_cur (entry_cur),
		.level_cur (level_q[addr_s1]),
		.entry_nxt (entry_nxt),
		.level_nxt (level_nxt)
	);

	// led table memory, registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_entry_s1 <= mem[rd_addr];
		if (wr_mem)
			mem[addr_s1] <= entry_nxt;
	end

	// address pipeline, latched command fields and output data register
	always_ff @(posedge clk) begin
		if (rd_en)
			addr_s1 <= rd_addr;
		if (in_acc) begin
			mode_q <= s_tdata[5:3];
			dur_q <= s_tdata[37:6];
		end
		if (out_load)
			out_q <= lv_ext[M_TDATA_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= FAST_PERIOD_RST;
			slow_q <= SLOW_PERIOD_RST;
		end else if (wr_en) begin
			if (wr_index == REG_FAST)
				fast_q <= wr_data;
			else
				slow_q <= wr_data;
		end
	end

	// sequencer, valid bits, levels, output valid flag and millisecond counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			millis_q <= '0;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			vld_q <= '0;
			level_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (rd_en)
				rd_vld_s1 <= vld_q[rd_addr];
			if (wr_mem) begin
				vld_q[addr_s1] <= 1'b1;
				level_q[addr_s1] <= level_nxt;
			end
			if (out_load)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_TICK) begin
							millis_q <= millis_q + 1'b1;
							cnt_q <= (IDX_W+1)'(1);
							state_q <= ST_POLL;
						end else if (idx_ok) begin
							state_q <= ST_SET;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SET: begin
					state_q <= ST_OUT;
				end
				ST_POLL: begin
					if (cnt_q < (IDX_W+1)'(LED_COUNT))
						cnt_q <= cnt_q + 1'b1;
					else
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/mlbc_checker.sv -----
// port-level checks of the multi-led blink controller, bound to the top level
// depends on mlbc_pkg and multi_led_blink_controller_core
module mlbc_checker import mlbc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a pending result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a pending result holds its levels
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: no second transaction right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is at work");

	// a result needs at least the table read before it appears
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind multi_led_blink_controller_core mlbc_checker u_mlbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
